FILE: sv/dwm_pkg.sv
// Shared constants, types and the track base table for the directory wildcard matcher.
package dwm_pkg;

    localparam int NAME_BYTES_DEF  = 16;
    localparam int TRACK_COUNT_DEF = 40;
    localparam int NAME_W          = 128;
    localparam int BLK_W           = 10;
    localparam int OFFSET_W        = 18;
    localparam int IMG_W           = 12;
    localparam int PLEN_W          = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int IN_TDATA_W      = 152;
    localparam int OUT_TDATA_W     = 24;

    localparam logic [7:0] PAD_BYTE  = 8'hA0;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;
    localparam logic [7:0] STOP_BYTE = 8'h2A;
    localparam logic [2:0] TYPE_SEQ  = 3'd1;
    localparam logic [2:0] TYPE_PRG  = 3'd2;

    localparam logic [IMG_W-1:0] IMG_BLOCKS_RST = 12'd683;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO,
        CFG_PAT_HI,
        CFG_PAT_LEN,
        CFG_IMG_BLOCKS
    } t_cfg_idx;

    // First block number of a one-based track in the zoned layout.
    function automatic logic [BLK_W-1:0] track_base(input logic [7:0] trk);
        int t;
        int b;
        t = int'(trk);
        if (t <= 1)
            b = 0;
        else if (t <= 17)
            b = 21 * (t - 1);
        else if (t <= 24)
            b = 357 + 19 * (t - 18);
        else if (t <= 30)
            b = 490 + 18 * (t - 25);
        else if (t <= 40)
            b = 598 + 17 * (t - 31);
        else
            b = 0;
        return BLK_W'(b);
    endfunction

endpackage

FILE: sv/disk_dir_wildcard_match_locate.sv
// Top level: directory entry wildcard name match and start block locator.
// Takes one directory entry beat per cycle unless the output stalls, and
// returns one result beat for each, in order. Stage one compares every
// name byte against the pattern and looks up the track base, stage two
// resolves the first stop or mismatch and adds the sector, stage three checks
// the block against the image size and forms the byte offset. Configuration
// writes are taken at once, every cycle, and must only happen while idle.
module disk_dir_wildcard_match_locate #(
    parameter int NAME_BYTES  = dwm_pkg::NAME_BYTES_DEF,
    parameter int TRACK_COUNT = dwm_pkg::TRACK_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dwm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // name_low_bytes[63:0], name_high_bytes[127:64], entry_type[135:128],
    // start_track[143:136], start_sector[151:144]
    input  logic [dwm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // name_matched[0], block_byte_offset[18:1], address_valid[19], zero[23:20]
    output logic [dwm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import dwm_pkg::*;

    localparam logic [PLEN_W-1:0] NB_LEN = PLEN_W'(NAME_BYTES);
    localparam logic [7:0]        TRK_MAX = 8'(TRACK_COUNT);

    // configuration
    logic [63:0]        r_pat_lo;
    logic [63:0]        r_pat_hi;
    logic [PLEN_W-1:0]  r_pat_len;
    logic [IMG_W-1:0]   r_img_blocks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo     <= '0;
            r_pat_hi     <= '0;
            r_pat_len    <= '0;
            r_img_blocks <= IMG_BLOCKS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_LO:     r_pat_lo     <= i_cfg_data;
                CFG_PAT_HI:     r_pat_hi     <= i_cfg_data;
                CFG_PAT_LEN:    r_pat_len    <= i_cfg_data[PLEN_W-1:0];
                CFG_IMG_BLOCKS: r_img_blocks <= i_cfg_data[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables
    logic r1_valid, r2_valid, r3_valid;
    logic en1, en2, en3;

    assign en3 = !r3_valid || m_axis_tready;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign s_axis_tready = en1;

    // stage 1: byte compares and track lookup
    logic [NAME_W-1:0]     in_name;
    logic [NAME_W-1:0]     pat;
    logic [2:0]            in_kind;
    logic [7:0]            in_trk;
    logic [7:0]            in_sec;
    logic [PLEN_W-1:0]     len_c;
    logic [NAME_BYTES-1:0] n_stop;
    logic [NAME_BYTES-1:0] n_fail;
    logic                  n_tail_ok;
    logic                  n_trk_ok;

    assign in_name = s_axis_tdata[127:0];
    assign pat     = {r_pat_hi, r_pat_lo};
    assign in_kind = s_axis_tdata[130:128];
    assign in_trk  = s_axis_tdata[143:136];
    assign in_sec  = s_axis_tdata[151:144];
    assign len_c   = (r_pat_len > NB_LEN) ? NB_LEN : r_pat_len;
    assign n_trk_ok = (in_trk >= 8'd1) && (in_trk <= TRK_MAX);

    always_comb begin
        for (int i = 0; i < NAME_BYTES; i++) begin
            logic [7:0] pb;
            logic       act;
            pb  = pat[i*8 +: 8];
            act = PLEN_W'(i) < len_c;
            n_stop[i] = act && (pb == STOP_BYTE);
            n_fail[i] = act && (pb != ANY_BYTE) && (pb != STOP_BYTE)
                        && (pb != in_name[i*8 +: 8]);
        end
    end

    always_comb begin
        if (len_c == NB_LEN)
            n_tail_ok = 1'b1;
        else
            n_tail_ok = (in_name[{len_c[3:0], 3'b000} +: 8] == PAD_BYTE);
    end

    logic [NAME_BYTES-1:0] r1_stop;
    logic [NAME_BYTES-1:0] r1_fail;
    logic                  r1_tail_ok;
    logic                  r1_kind_ok;
    logic                  r1_trk_ok;
    logic [BLK_W-1:0]      r1_base;
    logic [7:0]            r1_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= s_axis_tvalid;
        end
        if (en1) begin
            r1_stop    <= n_stop;
            r1_fail    <= n_fail;
            r1_tail_ok <= n_tail_ok;
            r1_kind_ok <= (in_kind == TYPE_SEQ) || (in_kind == TYPE_PRG);
            r1_trk_ok  <= n_trk_ok;
            r1_base    <= n_trk_ok ? track_base(in_trk) : '0;
            r1_sec     <= in_sec;
        end
    end

    // stage 2: first stop or mismatch wins, block number
    logic n_fail_first;

    always_comb begin
        logic seen_stop;
        seen_stop    = 1'b0;
        n_fail_first = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (r1_fail[i] && !seen_stop)
                n_fail_first = 1'b1;
            seen_stop = seen_stop | r1_stop[i];
        end
    end

    logic             r2_match;
    logic             r2_trk_ok;
    logic [BLK_W-1:0] r2_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
        if (en2) begin
            r2_match  <= r1_kind_ok && !n_fail_first && ((|r1_stop) || r1_tail_ok);
            r2_trk_ok <= r1_trk_ok;
            r2_block  <= r1_base + BLK_W'(r1_sec);
        end
    end

    // stage 3: image bound and byte offset
    logic                r3_match;
    logic [OFFSET_W-1:0] r3_offset;
    logic                r3_addr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
        if (en3) begin
            r3_match   <= r2_match;
            r3_offset  <= r2_trk_ok ? {r2_block, 8'h00} : '0;
            r3_addr_ok <= r2_trk_ok && (IMG_W'(r2_block) < r_img_blocks);
        end
    end

    assign m_axis_tvalid = r3_valid;
    assign m_axis_tdata  = {4'b0000, r3_addr_ok, r3_offset, r3_match};

endmodule

FILE: sv/dwm_chk.sv
// Port checker for the directory wildcard matcher, bound to the top level.
module dwm_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dwm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_offset_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:1] == 8'h00 && m_axis_tdata[23:20] == 4'h0)
        else $error("offset not block aligned or padding set");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind disk_dir_wildcard_match_locate dwm_chk u_dwm_chk (.*);

FILE: test/tb_disk_dir_wildcard_match_locate.sv
// Testbench: random and directed directory entries checked against an in-bench matcher/locator.
module tb_disk_dir_wildcard_match_locate;
    timeunit 1ns;
    timeprecision 1ps;

    import dwm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 280;
    localparam int RAND_PHASES  = 6;
    localparam int HOLD_AT_BEAT = 400;
    localparam int HOLD_CYCLES  = 300;

    // Laid out exactly as s_axis_tdata, lowest field last.
    typedef struct packed {
        logic [7:0]   sector;
        logic [7:0]   track;
        logic [7:0]   kind_byte;
        logic [127:0] name;
    } t_entry;

    // Laid out as m_axis_tdata[19:0].
    typedef struct packed {
        logic        valid;
        logic [17:0] offset;
        logic        hit;
    } t_dir_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Mirror of the block's registers.
    logic [127:0]       pattern = '0;
    logic [PLEN_W-1:0]  pat_len = '0;
    logic [IMG_W-1:0]   img_blocks = IMG_BLOCKS_RST;

    t_entry      pending_entries[$];
    t_dir_result expected_results[$];

    int unsigned errors = 0;
    int unsigned entries_in = 0;
    int unsigned cycles = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    disk_dir_wildcard_match_locate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned sectors_on(int unsigned trk);
        if (trk <= 17)
            return 21;
        else if (trk <= 24)
            return 19;
        else if (trk <= 30)
            return 18;
        return 17;
    endfunction

    function automatic logic name_hit(logic [127:0] nm);
        int unsigned n;
        logic [7:0]  p;
        n = (pat_len > NAME_BYTES_DEF) ? NAME_BYTES_DEF : pat_len;
        for (int i = 0; i < n; i++) begin
            p = pattern[i*8 +: 8];
            if (p == ANY_BYTE)
                continue;
            if (p == STOP_BYTE)
                return 1'b1;
            if (p != nm[i*8 +: 8])
                return 1'b0;
        end
        if (n < NAME_BYTES_DEF)
            return nm[n*8 +: 8] == PAD_BYTE;
        return 1'b1;
    endfunction

    function automatic t_dir_result locate_and_match(t_entry e);
        t_dir_result r;
        int unsigned blk;
        r = '0;
        if (e.kind_byte[2:0] == TYPE_SEQ || e.kind_byte[2:0] == TYPE_PRG)
            r.hit = name_hit(e.name);
        if (e.track >= 1 && e.track <= TRACK_COUNT_DEF) begin
            blk = e.sector;
            for (int unsigned t = 1; t < e.track; t++)
                blk += sectors_on(t);
            r.offset = 18'(blk * 256);
            r.valid  = blk < img_blocks;
        end
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int unsigned idle_len(bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [127:0] rand_pattern();
        logic [127:0] p;
        int unsigned  r;
        for (int i = 0; i < 16; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                p[i*8 +: 8] = ANY_BYTE;
            else if (r < 20)
                p[i*8 +: 8] = STOP_BYTE;
            else
                p[i*8 +: 8] = 8'($urandom);
        end
        return p;
    endfunction

    // Name built to fit the current pattern, with random content where it allows.
    function automatic logic [127:0] fitting_name();
        logic [127:0] nm;
        logic [7:0]   p;
        int unsigned  n;
        bit           stopped;
        stopped = 1'b0;
        n = (pat_len > NAME_BYTES_DEF) ? NAME_BYTES_DEF : pat_len;
        for (int i = 0; i < 16; i++) begin
            nm[i*8 +: 8] = 8'($urandom);
            if (!stopped && i < n) begin
                p = pattern[i*8 +: 8];
                if (p == STOP_BYTE)
                    stopped = 1'b1;
                else if (p != ANY_BYTE)
                    nm[i*8 +: 8] = p;
            end else if (!stopped && i == n) begin
                nm[i*8 +: 8] = PAD_BYTE;
            end else if ($urandom_range(0, 1)) begin
                nm[i*8 +: 8] = PAD_BYTE;
            end
        end
        return nm;
    endfunction

    function automatic t_entry rand_entry();
        t_entry e;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            e.name = fitting_name();
            if ($urandom_range(0, 3) == 0)
                e.name[$urandom_range(0, 127)] ^= 1'b1;
        end else begin
            e.name = {$urandom, $urandom, $urandom, $urandom};
        end
        if ($urandom_range(0, 9) < 8)
            e.kind_byte = {5'($urandom), $urandom_range(0, 1) ? TYPE_SEQ : TYPE_PRG};
        else
            e.kind_byte = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 85)
            e.track = 8'($urandom_range(1, TRACK_COUNT_DEF));
        else if (r < 90)
            e.track = 8'd0;
        else
            e.track = 8'($urandom);
        if ($urandom_range(0, 99) < 85 && e.track >= 1 && e.track <= TRACK_COUNT_DEF)
            e.sector = 8'($urandom_range(0, sectors_on(e.track) - 1));
        else
            e.sector = 8'($urandom);
        return e;
    endfunction

    function automatic void add_entry(logic [63:0] lo, logic [63:0] hi, logic [7:0] ty,
                                      logic [7:0] trk, logic [7:0] sec);
        t_entry e;
        e.name      = {hi, lo};
        e.kind_byte = ty;
        e.track     = trk;
        e.sector    = sec;
        pending_entries.push_back(e);
    endfunction

    // Called at a rising edge; writes all four registers back to back.
    task automatic write_config(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                                logic [11:0] blocks);
        logic [63:0] vals[4];
        vals = '{lo, hi, 64'(len), 64'(blocks)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_idx'(k))
                CFG_PAT_LO:     pattern[63:0]   = vals[k];
                CFG_PAT_HI:     pattern[127:64] = vals[k];
                CFG_PAT_LEN:    pat_len         = vals[k][PLEN_W-1:0];
                CFG_IMG_BLOCKS: img_blocks      = vals[k][IMG_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Checked between edges so the driver's updates have settled.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_entries.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Entry driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(locate_and_match(t_entry'(s_axis_tdata)));
                entries_in <= entries_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_entries.size() != 0) begin
                    s_axis_tdata  <= pending_entries.pop_front();
                    s_axis_tvalid <= 1'b1;
                    tx_gap <= idle_len(tx_idle_on);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready, with one long hold-off to back up the pipeline
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && entries_in >= HOLD_AT_BEAT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap <= idle_len(rx_idle_on);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_dir_result got;
        t_dir_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_dir_result'(m_axis_tdata[19:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit) begin
                    $error("name_matched: expected %0d, got %0d", want.hit, got.hit);
                    errors++;
                end
                if (got.offset !== want.offset) begin
                    $error("block_byte_offset: expected %0d, got %0d",
                           want.offset, got.offset);
                    errors++;
                end
                if (got.valid !== want.valid) begin
                    $error("address_valid: expected %0d, got %0d", want.valid, got.valid);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [4:0]   len;
        logic [11:0]  blocks;
        logic [127:0] nm;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty pattern, 683 blocks
        add_entry({8{PAD_BYTE}}, {8{PAD_BYTE}}, 8'h82, 8'd1, 8'd0);
        add_entry({8{PAD_BYTE}}, {8{PAD_BYTE}}, 8'h01, 8'd35, 8'd16);
        add_entry({8{PAD_BYTE}}, {8{PAD_BYTE}}, 8'h02, 8'd36, 8'd0);
        for (int k = 0; k < 8; k++)
            add_entry({8{PAD_BYTE}}, '0, {5'b10000, 3'(k)}, 8'(k + 17), 8'(k));
        add_entry('0, '0, 8'h00, 8'd0, 8'd0);
        add_entry('1, '1, 8'hFF, 8'hFF, 8'hFF);
        add_entry('1, '1, 8'hFA, 8'd40, 8'd255);
        add_entry({56'h0, PAD_BYTE}, '1, 8'h01, 8'd41, 8'd3);
        add_entry({56'hFF, PAD_BYTE}, '0, 8'h02, 8'd18, 8'd18);
        add_entry(64'h1234, 64'h5678, 8'h01, 8'd24, 8'd0);
        add_entry({8{PAD_BYTE}}, '0, 8'h02, 8'd25, 8'd17);
        add_entry({8{PAD_BYTE}}, '0, 8'h01, 8'd30, 8'd0);
        add_entry({8{PAD_BYTE}}, '0, 8'h02, 8'd31, 8'd16);
        add_entry({8{PAD_BYTE}}, '0, 8'h02, 8'd17, 8'd255);
        drain();

        for (int ph = 1; ph <= RAND_PHASES; ph++) begin
            case (ph)
                1: begin len = 5'd16; blocks = 12'd4095; end
                2: begin len = 5'd0;  blocks = 12'd0; end
                3: begin len = 5'd31; blocks = IMG_BLOCKS_RST; end
                4: begin len = 5'($urandom_range(1, 15)); blocks = 12'($urandom); end
                5: begin len = 5'($urandom_range(17, 30)); blocks = 12'($urandom); end
                default: begin len = 5'($urandom_range(0, 16)); blocks = 12'd4095; end
            endcase
            tx_idle_on = (ph % 3) != 1;
            rx_idle_on = (ph % 3) != 2;
            write_config(rand_pattern(), rand_pattern(), len, blocks);
            if (ph == 1) begin
                // Full-width pattern, name built to match it
                nm = fitting_name();
                add_entry(nm[63:0], nm[127:64], 8'h82, 8'd1, 8'd0);
            end
            repeat (PHASE_ITEMS)
                pending_entries.push_back(rand_entry());
            drain();
        end

        if (errors == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dwm_pkg.sv
sv/disk_dir_wildcard_match_locate.sv
sv/dwm_chk.sv
test/tb_disk_dir_wildcard_match_locate.sv
